// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared types, constants and the control store of the text console writer
// holds the item and result structs, the control word layout and the microcode table
// no dependencies
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_TOTAL = COLUMNS * ROWS;
    localparam int CELL_W     = 16;
    localparam int ADDR_W     = $clog2(CELL_TOTAL);
    localparam int CUR_W      = $clog2(CELL_TOTAL + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int REP_W      = 4;
    localparam int PC_W       = 5;

    localparam logic [CUR_W-1:0] CUR_END         = CUR_W'(CELL_TOTAL);
    localparam logic [CUR_W-1:0] CUR_CELL_LAST   = CUR_W'(CELL_TOTAL - 1);
    localparam logic [CUR_W-1:0] CUR_BOTTOM_ROW  = CUR_W'(CELL_TOTAL - COLUMNS);
    localparam logic [CUR_W-1:0] CUR_SCROLL_LAST = CUR_W'(CELL_TOTAL - COLUMNS - 1);
    localparam logic [CUR_W-1:0] CUR_COLS        = CUR_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST        = COL_W'(COLUMNS - 1);

    // character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd7;

    // operation codes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [10:0] cursor_index;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } result_t;

    // control word fields
    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_CUR  = 3'd1,
        RD_IDX  = 3'd2,
        RD_SCR0 = 3'd3,
        RD_SCR1 = 3'd4
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_CHAR  = 3'd1,
        WR_SPACE = 3'd2,
        WR_MARK  = 3'd3,
        WR_COPY  = 3'd4,
        WR_ZERO  = 3'd5
    } wr_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD     = 3'd0,
        CUR_ADV      = 3'd1,
        CUR_BACK     = 3'd2,
        CUR_NL       = 3'd3,
        CUR_HOME     = 3'd4,
        CUR_SET      = 3'd5,
        CUR_COL_LOAD = 3'd6
    } cur_op_t;

    typedef enum logic [2:0] {
        CNT_HOLD   = 3'd0,
        CNT_CLR    = 3'd1,
        CNT_INC    = 3'd2,
        CNT_BOTTOM = 3'd3,
        CNT_SAT    = 3'd4,
        CNT_MOD    = 3'd5
    } cnt_op_t;

    typedef enum logic [1:0] {
        REP_HOLD = 2'd0,
        REP_LOAD = 2'd1,
        REP_DEC  = 2'd2,
        REP_CLR  = 2'd3
    } rep_op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT = 3'd0,
        SEQ_JUMP = 3'd1,
        SEQ_CALL = 3'd2,
        SEQ_RET  = 3'd3,
        SEQ_MAP  = 3'd4
    } seq_op_t;

    typedef enum logic [2:0] {
        C_ALWAYS      = 3'd0,
        C_AT_END      = 3'd1,
        C_REP_LEFT    = 3'd2,
        C_SCROLL_MORE = 3'd3,
        C_CLEAR_MORE  = 3'd4,
        C_COL_WRAP    = 3'd5
    } cond_sel_t;

    typedef struct packed {
        rd_sel_t         rd;
        wr_sel_t         wr;
        cur_op_t         cur;
        cnt_op_t         cnt;
        rep_op_t         rep;
        seq_op_t         seq;
        cond_sel_t       cond;
        logic [PC_W-1:0] target;
        logic            done;
        logic            res_read;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic at_end;
        logic rep_left;
        logic scroll_more;
        logic clear_more;
        logic col_wrap;
    } flags_t;

    // program addresses
    localparam logic [PC_W-1:0] U_CLR     = PC_W'(0);
    localparam logic [PC_W-1:0] U_IDLE    = PC_W'(1);
    localparam logic [PC_W-1:0] U_TAB     = PC_W'(2);
    localparam logic [PC_W-1:0] U_TAB_PUT = PC_W'(3);
    localparam logic [PC_W-1:0] U_CHK     = PC_W'(4);
    localparam logic [PC_W-1:0] U_LOOP    = PC_W'(5);
    localparam logic [PC_W-1:0] U_MK0     = PC_W'(6);
    localparam logic [PC_W-1:0] U_MK1     = PC_W'(7);
    localparam logic [PC_W-1:0] U_PUT     = PC_W'(8);
    localparam logic [PC_W-1:0] U_NL      = PC_W'(9);
    localparam logic [PC_W-1:0] U_BS0     = PC_W'(10);
    localparam logic [PC_W-1:0] U_BS1     = PC_W'(11);
    localparam logic [PC_W-1:0] U_BS2     = PC_W'(12);
    localparam logic [PC_W-1:0] U_BS3     = PC_W'(13);
    localparam logic [PC_W-1:0] U_BS4     = PC_W'(14);
    localparam logic [PC_W-1:0] U_RD0     = PC_W'(15);
    localparam logic [PC_W-1:0] U_RD1     = PC_W'(16);
    localparam logic [PC_W-1:0] U_SET0    = PC_W'(17);
    localparam logic [PC_W-1:0] U_SET1    = PC_W'(18);
    localparam logic [PC_W-1:0] U_SET2    = PC_W'(19);
    localparam logic [PC_W-1:0] U_NOP     = PC_W'(20);
    localparam logic [PC_W-1:0] U_SCR0    = PC_W'(21);
    localparam logic [PC_W-1:0] U_SCR1    = PC_W'(22);
    localparam logic [PC_W-1:0] U_SCR2    = PC_W'(23);
    localparam logic [PC_W-1:0] U_SCR3    = PC_W'(24);
    localparam logic [PC_W-1:0] U_SCR4    = PC_W'(25);
    localparam logic [PC_W-1:0] U_SCR5    = PC_W'(26);

    // control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        begin
            w.rd       = RD_NONE;
            w.wr       = WR_NONE;
            w.cur      = CUR_HOLD;
            w.cnt      = CNT_HOLD;
            w.rep      = REP_HOLD;
            w.seq      = SEQ_NEXT;
            w.cond     = C_ALWAYS;
            w.target   = U_IDLE;
            w.done     = 1'b0;
            w.res_read = 1'b0;
            case (pc)
                // clearing pass after reset
                U_CLR:
                begin
                    w.wr     = WR_ZERO;
                    w.cnt    = CNT_INC;
                    w.seq    = SEQ_JUMP;
                    w.cond   = C_CLEAR_MORE;
                    w.target = U_CLR;
                end
                U_IDLE:
                begin
                    w.seq = SEQ_MAP;
                end
                // tab: a run of spaces up to the next tab stop
                U_TAB:
                begin
                    w.rep = REP_LOAD;
                end
                U_TAB_PUT:
                begin
                    w.wr  = WR_SPACE;
                    w.cur = CUR_ADV;
                    w.rep = REP_DEC;
                end
                U_CHK:
                begin
                    w.seq    = SEQ_CALL;
                    w.cond   = C_AT_END;
                    w.target = U_SCR0;
                end
                U_LOOP:
                begin
                    w.seq    = SEQ_JUMP;
                    w.cond   = C_REP_LEFT;
                    w.target = U_TAB_PUT;
                end
                // set the attribute of the cursor cell, keep its character
                U_MK0:
                begin
                    w.rd = RD_CUR;
                end
                U_MK1:
                begin
                    w.wr   = WR_MARK;
                    w.done = 1'b1;
                    w.seq  = SEQ_JUMP;
                end
                U_PUT:
                begin
                    w.wr     = WR_CHAR;
                    w.cur    = CUR_ADV;
                    w.rep    = REP_CLR;
                    w.seq    = SEQ_JUMP;
                    w.target = U_CHK;
                end
                U_NL:
                begin
                    w.cur    = CUR_NL;
                    w.rep    = REP_CLR;
                    w.seq    = SEQ_JUMP;
                    w.target = U_CHK;
                end
                // backspace
                U_BS0:
                begin
                    w.cur = CUR_BACK;
                end
                U_BS1:
                begin
                    w.wr  = WR_SPACE;
                    w.cur = CUR_ADV;
                end
                U_BS2:
                begin
                    w.rd = RD_CUR;
                end
                U_BS3:
                begin
                    w.wr = WR_MARK;
                end
                U_BS4:
                begin
                    w.cur    = CUR_BACK;
                    w.seq    = SEQ_JUMP;
                    w.target = U_MK0;
                end
                // read a cell
                U_RD0:
                begin
                    w.rd = RD_IDX;
                end
                U_RD1:
                begin
                    w.done     = 1'b1;
                    w.res_read = 1'b1;
                    w.seq      = SEQ_JUMP;
                end
                // set cursor, column found by repeated subtraction
                U_SET0:
                begin
                    w.cur = CUR_SET;
                    w.cnt = CNT_SAT;
                end
                U_SET1:
                begin
                    w.cnt    = CNT_MOD;
                    w.seq    = SEQ_JUMP;
                    w.cond   = C_COL_WRAP;
                    w.target = U_SET1;
                end
                U_SET2:
                begin
                    w.cur  = CUR_COL_LOAD;
                    w.done = 1'b1;
                    w.seq  = SEQ_JUMP;
                end
                U_NOP:
                begin
                    w.done = 1'b1;
                    w.seq  = SEQ_JUMP;
                end
                // scroll subroutine: copy rows up, clear bottom row
                U_SCR0:
                begin
                    w.cnt = CNT_CLR;
                end
                U_SCR1:
                begin
                    w.rd = RD_SCR0;
                end
                U_SCR2:
                begin
                    w.rd     = RD_SCR1;
                    w.wr     = WR_COPY;
                    w.cnt    = CNT_INC;
                    w.seq    = SEQ_JUMP;
                    w.cond   = C_SCROLL_MORE;
                    w.target = U_SCR2;
                end
                U_SCR3:
                begin
                    w.cnt = CNT_BOTTOM;
                end
                U_SCR4:
                begin
                    w.wr     = WR_ZERO;
                    w.cnt    = CNT_INC;
                    w.seq    = SEQ_JUMP;
                    w.cond   = C_CLEAR_MORE;
                    w.target = U_SCR4;
                end
                U_SCR5:
                begin
                    w.cur = CUR_HOME;
                    w.seq = SEQ_RET;
                end
                default:
                begin
                    w.seq = SEQ_JUMP;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// tcw_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_seq.sv =====
// tcw_seq: microcode sequencer, step counter, return register and entry map
// depends on tcw_pkg for the control store and types
`default_nettype none

module tcw_seq
    import tcw_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire cmd_t   cmd,
    input  wire flags_t flags,
    output ctrl_t       ctrl,
    output logic        busy
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] ret_reg, ret_next;
    logic [PC_W-1:0] pc_inc;
    logic [PC_W-1:0] entry;
    logic            cond_hit;

    assign ctrl   = ucode(pc_reg);
    assign busy   = (pc_reg != U_IDLE);
    assign pc_inc = pc_reg + PC_W'(1);

    // entry point for a new item
    always_comb
    begin
        case (cmd.operation)
            OP_PUT:
            begin
                if (cmd.char_code == CH_NEWLINE)
                begin
                    entry = U_NL;
                end
                else if (cmd.char_code == CH_TAB)
                begin
                    entry = U_TAB;
                end
                else if (cmd.char_code == CH_BACKSPACE)
                begin
                    entry = U_BS0;
                end
                else
                begin
                    entry = U_PUT;
                end
            end
            OP_READ: entry = U_RD0;
            OP_SET:  entry = U_SET0;
            default: entry = U_NOP;
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:      cond_hit = 1'b1;
            C_AT_END:      cond_hit = flags.at_end;
            C_REP_LEFT:    cond_hit = flags.rep_left;
            C_SCROLL_MORE: cond_hit = flags.scroll_more;
            C_CLEAR_MORE:  cond_hit = flags.clear_more;
            C_COL_WRAP:    cond_hit = flags.col_wrap;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next  = pc_inc;
        ret_next = ret_reg;
        case (ctrl.seq)
            SEQ_NEXT: pc_next = pc_inc;
            SEQ_JUMP: pc_next = cond_hit ? ctrl.target : pc_inc;
            SEQ_CALL:
            begin
                if (cond_hit)
                begin
                    ret_next = pc_inc;
                    pc_next  = ctrl.target;
                end
            end
            SEQ_RET:  pc_next = ret_reg;
            SEQ_MAP:  pc_next = start ? entry : pc_reg;
            default:  pc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= U_CLR;
            ret_reg <= U_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer_top.sv =====
// text_console_char_writer_top: 80x25 text console with cursor, put/read/set items
// depends on tcw_pkg, tcw_seq and tcw_ram
`default_nettype none

// A text console that keeps an 80x25 screen of 16-bit cells (low byte
// character, high byte attribute) in one ram and a linear cursor. An item
// is taken when start is high and busy is low, and exactly one result comes
// back on result with result_valid high for a single cycle; the receiver
// cannot stall it, so it must take every result as it appears. busy is high
// for the whole of an item and during the clearing pass that zeroes the
// screen after reset (one cell per cycle, busy high throughout). Control is
// a microcode program stepped one word per cycle, and the single ram write
// port and registered read port set the steps of each item; set cursor
// finds the column by subtracting 80 once per row. A put that runs off the
// bottom row adds a scroll that copies each row up by one and clears the
// bottom row. The result is on the ports in the first cycle that busy is
// low again. cfg_write_en writes the attribute byte used for written cells
// and for the cursor cell; write it only while busy is low.

module text_console_char_writer_top
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire cmd_t       cmd,
    output result_t         result,
    output logic            result_valid,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data
);

    ctrl_t  ctrl;
    flags_t flags;

    cmd_t             cmd_reg;
    logic [7:0]       attr_reg;
    logic [CUR_W-1:0] cur_reg, cur_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CUR_W-1:0] cnt_reg, cnt_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    result_t          result_reg, result_next;
    logic             result_valid_reg;

    logic              accept;
    logic              idx_in_range;
    logic [CUR_W-1:0]  idx_sat;
    logic [CUR_W-1:0]  rd_addr_full;
    logic [CUR_W-1:0]  wr_addr_full;
    logic              rd_en;
    logic              wr_en;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] rd_data;

    // program sequencer
    tcw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    assign accept = start && !busy;

    // cell index out of range reads as zero, and saturates for set cursor
    assign idx_in_range = (CUR_W'(cmd_reg.cell_index) < CUR_END);
    assign idx_sat      = idx_in_range ? CUR_W'(cmd_reg.cell_index) : CUR_CELL_LAST;

    // branch conditions
    assign flags.at_end      = (cur_reg == CUR_END);
    assign flags.rep_left    = (rep_reg != '0);
    assign flags.scroll_more = (cnt_reg != CUR_SCROLL_LAST);
    assign flags.clear_more  = (cnt_reg != CUR_CELL_LAST);
    assign flags.col_wrap    = (cnt_reg >= CUR_COLS);

    // ram read side
    always_comb
    begin
        case (ctrl.rd)
            RD_CUR:  rd_addr_full = cur_reg;
            RD_IDX:  rd_addr_full = CUR_W'(cmd_reg.cell_index);
            RD_SCR0: rd_addr_full = cnt_reg + CUR_COLS;
            RD_SCR1: rd_addr_full = cnt_reg + CUR_COLS + CUR_W'(1);
            default: rd_addr_full = cur_reg;
        endcase
    end

    // the last copy step looks one cell past the screen, so gate it
    assign rd_en = (ctrl.rd != RD_NONE) && (rd_addr_full < CUR_END);

    // ram write side
    always_comb
    begin
        wr_en        = 1'b1;
        wr_addr_full = cur_reg;
        case (ctrl.wr)
            WR_CHAR:  wr_data = {attr_reg, cmd_reg.char_code};
            WR_SPACE: wr_data = {attr_reg, CH_SPACE};
            WR_MARK:  wr_data = {attr_reg, rd_data[7:0]};
            WR_COPY:
            begin
                wr_addr_full = cnt_reg;
                wr_data      = rd_data;
            end
            WR_ZERO:
            begin
                wr_addr_full = cnt_reg;
                wr_data      = '0;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = '0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_TOTAL)
    ) u_screen (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr_full[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr_full[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // cursor and column
    always_comb
    begin
        cur_next = cur_reg;
        col_next = col_reg;
        case (ctrl.cur)
            CUR_ADV:
            begin
                cur_next = cur_reg + CUR_W'(1);
                col_next = (col_reg == COL_LAST) ? '0 : col_reg + COL_W'(1);
            end
            CUR_BACK:
            begin
                // cell 0 stays put
                if (cur_reg != '0)
                begin
                    cur_next = cur_reg - CUR_W'(1);
                    col_next = (col_reg == '0) ? COL_LAST : col_reg - COL_W'(1);
                end
            end
            CUR_NL:
            begin
                cur_next = cur_reg - CUR_W'(col_reg) + CUR_COLS;
                col_next = '0;
            end
            CUR_HOME:
            begin
                cur_next = CUR_BOTTOM_ROW;
                col_next = '0;
            end
            CUR_SET:      cur_next = idx_sat;
            CUR_COL_LOAD: col_next = cnt_reg[COL_W-1:0];
            default:      cur_next = cur_reg;
        endcase
    end

    // scratch counter: ram sweeps and column extraction
    always_comb
    begin
        case (ctrl.cnt)
            CNT_CLR:    cnt_next = '0;
            CNT_INC:    cnt_next = cnt_reg + CUR_W'(1);
            CNT_BOTTOM: cnt_next = CUR_BOTTOM_ROW;
            CNT_SAT:    cnt_next = idx_sat;
            CNT_MOD:    cnt_next = flags.col_wrap ? cnt_reg - CUR_COLS : cnt_reg;
            default:    cnt_next = cnt_reg;
        endcase
    end

    // spaces left in a tab
    always_comb
    begin
        case (ctrl.rep)
            REP_LOAD: rep_next = REP_W'(4'd8 - {1'b0, col_reg[2:0]});
            REP_DEC:  rep_next = rep_reg - REP_W'(1);
            REP_CLR:  rep_next = '0;
            default:  rep_next = rep_reg;
        endcase
    end

    // result of the item, shown the cycle after its last step
    always_comb
    begin
        result_next              = result_reg;
        result_next.cursor_index = 11'(cur_reg);
        result_next.read_char    = '0;
        result_next.read_attr    = '0;
        if (ctrl.res_read && idx_in_range)
        begin
            result_next.read_char = rd_data[7:0];
            result_next.read_attr = rd_data[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg         <= ATTR_RESET;
            cur_reg          <= '0;
            col_reg          <= '0;
            cnt_reg          <= '0;
            rep_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            cur_reg          <= cur_next;
            col_reg          <= col_next;
            cnt_reg          <= cnt_next;
            rep_reg          <= rep_next;
            result_valid_reg <= ctrl.done;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.done)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire
